/* design/tflp_pkg.sv */
// Shared types, codes and helper functions of the text frame line parser.
// Depends on nothing; every module of the parser imports it.
package tflp_pkg;

    localparam int LINE_BYTES_DEF  = 128;
    localparam int TYPE_MAX_DEF    = 16;
    localparam int PAYLOAD_MAX_DEF = 32;
    localparam int MAX_DEC_DIGITS  = 10;
    localparam int PLEN_W          = 5;

    localparam logic [7:0] CRC_POLY = 8'h07;
    localparam logic [7:0] CRC_INIT = 8'h00;

    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_ZERO = 8'h30;

    localparam logic [23:0] PFX_EVT = 24'h455654;
    localparam logic [23:0] PFX_CMD = 24'h434D44;
    localparam logic [23:0] PFX_RSP = 24'h525350;

    localparam logic [1:0] PFX_CODE_EVT = 2'd0;
    localparam logic [1:0] PFX_CODE_CMD = 2'd1;
    localparam logic [1:0] PFX_CODE_RSP = 2'd2;

    localparam logic [1:0] ST_COMPLETE = 2'd0;
    localparam logic [1:0] ST_MALFORMED = 2'd1;
    localparam logic [1:0] ST_OVERLONG = 2'd2;
    localparam logic [1:0] ST_FOREIGN  = 2'd3;

    localparam logic [1:0] KIND_HDR  = 2'd0;
    localparam logic [1:0] KIND_TYPE = 2'd1;
    localparam logic [1:0] KIND_PAY  = 2'd2;

    localparam logic [1:0] VERDICT_NONE   = 2'd0;
    localparam logic [1:0] VERDICT_STATUS = 2'd1;
    localparam logic [1:0] VERDICT_FRAME  = 2'd2;

    typedef struct packed {
        logic store;
        logic newline;
        logic load_status;
        logic load_hdr;
        logic start_run;
        logic rd;
        logic load_data;
    } tflp_cmd_t;

    typedef struct packed {
        logic [1:0] verdict;
        logic       slot_free;
        logic       run_done;
        logic       rx_is_lf;
    } tflp_stat_t;

    // One byte of CRC-8/ATM, MSB first.
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // Returns {valid, nibble} for one ASCII hex character.
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[8'h30:8'h39]})
            r = {1'b1, 4'(c - 8'h30)};
        else if (c inside {[8'h41:8'h46]})
            r = {1'b1, 4'(c - 8'h37)};
        else if (c inside {[8'h61:8'h66]})
            r = {1'b1, 4'(c - 8'h57)};
        return r;
    endfunction

endpackage

/* design/text_frame_line_parser.sv */
// Top level of the text frame line parser: ties controller and datapath.
// Depends on tflp_pkg, tflp_ctrl and tflp_dp.
//
// The parser takes one received byte per transfer on the rx channel and one
// byte per clock while a line is being collected; the frame is checked on
// the fly as the bytes are stored, so no scan of the line follows the
// newline. Carriage returns are dropped and bytes past LINE_BYTES-1 mark the
// line overlong. The verdict is registered at the edge that takes the
// newline. After it the rx channel is held off, and once the result register
// has room a status item or the header is loaded into it. Each type and
// payload byte of a frame is then read from the registered line store in
// S_RD and loaded into the result register in S_LD, waiting while the
// result side stalls. Input stays blocked until the last item of the line
// is loaded. Blank lines produce no result and block input only in S_FIN.
// The result register lets the next line's bytes be taken while the final
// result of a line still waits.
module text_frame_line_parser #(
    parameter int LINE_BYTES  = tflp_pkg::LINE_BYTES_DEF,
    parameter int TYPE_MAX    = tflp_pkg::TYPE_MAX_DEF,
    parameter int PAYLOAD_MAX = tflp_pkg::PAYLOAD_MAX_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    output logic        rx_ready,
    input  logic [7:0]  rx_byte,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [1:0]  status,
    output logic [1:0]  kind,
    output logic [1:0]  prefix,
    output logic [31:0] timestamp_ms,
    output logic [3:0]  type_length,
    output logic [4:0]  payload_length,
    output logic [7:0]  data_byte,
    output logic        last,
    output logic [31:0] accepted_count,
    output logic [31:0] rejected_count,
    output logic [31:0] overlong_count,
    output logic [31:0] ignored_count
);
    import tflp_pkg::*;

    tflp_cmd_t  cmd;
    tflp_stat_t stat;

    // The controller owns the handshake and the order of result items.
    tflp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx_valid),
        .rx_ready (rx_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath stores the line, parses it and holds the result register.
    tflp_dp #(
        .LINE_BYTES  (LINE_BYTES),
        .TYPE_MAX    (TYPE_MAX),
        .PAYLOAD_MAX (PAYLOAD_MAX)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .rx_byte        (rx_byte),
        .cmd            (cmd),
        .stat           (stat),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .status         (status),
        .kind           (kind),
        .prefix         (prefix),
        .timestamp_ms   (timestamp_ms),
        .type_length    (type_length),
        .payload_length (payload_length),
        .data_byte      (data_byte),
        .last           (last),
        .accepted_count (accepted_count),
        .rejected_count (rejected_count),
        .overlong_count (overlong_count),
        .ignored_count  (ignored_count)
    );

    // Type and payload bytes only ever belong to a complete frame.
    a_data_complete: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && kind != KIND_HDR) |-> (status == ST_COMPLETE))
        else $error("data item carries a non-complete status");

    // A status item is always the only result of its line.
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && status != ST_COMPLETE) |-> last)
        else $error("status item not marked last");

    // The accepted counter moves by exactly one when it moves.
    a_acc_step: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && $past(res_valid) && !$stable(accepted_count))
        |-> (accepted_count == $past(accepted_count) + 32'd1))
        else $error("accepted count jumped");

endmodule

/* design/tflp_ctrl.sv */
// Controller of the text frame line parser: byte intake and result sequencing.
// Depends on tflp_pkg; drives the datapath through tflp_cmd_t commands.
module tflp_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rx_valid,
    output logic                  rx_ready,
    input  tflp_pkg::tflp_stat_t  stat,
    output tflp_pkg::tflp_cmd_t   cmd
);
    import tflp_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_FIN  = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;
    localparam logic [1:0] S_LD   = 2'd3;

    logic [1:0] state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        rx_ready   = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (rx_valid)
                begin
                    if (stat.rx_is_lf)
                    begin
                        cmd.newline = 1'b1;
                        state_next  = S_FIN;
                    end
                    else
                    begin
                        cmd.store = 1'b1;
                    end
                end
            end
            S_FIN:
            begin
                if (stat.verdict == VERDICT_NONE)
                    state_next = S_IDLE;
                else if (stat.slot_free)
                begin
                    if (stat.verdict == VERDICT_FRAME)
                    begin
                        cmd.load_hdr  = 1'b1;
                        cmd.start_run = 1'b1;
                        state_next    = S_RD;
                    end
                    else
                    begin
                        cmd.load_status = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
            end
            S_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_LD;
            end
            S_LD:
            begin
                if (stat.slot_free)
                begin
                    cmd.load_data = 1'b1;
                    state_next    = stat.run_done ? S_IDLE : S_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

/* design/tflp_dp.sv */
// Datapath of the text frame line parser: line store, on-the-fly frame parser,
// CRC, counters and the result register. Depends on tflp_pkg.
module tflp_dp #(
    parameter int LINE_BYTES  = tflp_pkg::LINE_BYTES_DEF,
    parameter int TYPE_MAX    = tflp_pkg::TYPE_MAX_DEF,
    parameter int PAYLOAD_MAX = tflp_pkg::PAYLOAD_MAX_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           rx_byte,
    input  tflp_pkg::tflp_cmd_t  cmd,
    output tflp_pkg::tflp_stat_t stat,
    output logic                 res_valid,
    input  logic                 res_ready,
    output logic [1:0]           status,
    output logic [1:0]           kind,
    output logic [1:0]           prefix,
    output logic [31:0]          timestamp_ms,
    output logic [3:0]           type_length,
    output logic [4:0]           payload_length,
    output logic [7:0]           data_byte,
    output logic                 last,
    output logic [31:0]          accepted_count,
    output logic [31:0]          rejected_count,
    output logic [31:0]          overlong_count,
    output logic [31:0]          ignored_count
);
    import tflp_pkg::*;

    localparam int AW  = $clog2(LINE_BYTES - 1);
    localparam int FW  = $clog2(LINE_BYTES);
    localparam int TLW = $clog2(TYPE_MAX);

    localparam logic [3:0] PH_MS   = 4'd0;
    localparam logic [3:0] PH_TYPE = 4'd1;
    localparam logic [3:0] PH_PLEN = 4'd2;
    localparam logic [3:0] PH_PAY  = 4'd3;
    localparam logic [3:0] PH_SP2  = 4'd4;
    localparam logic [3:0] PH_STAR = 4'd5;
    localparam logic [3:0] PH_HEX1 = 4'd6;
    localparam logic [3:0] PH_HEX2 = 4'd7;
    localparam logic [3:0] PH_DONE = 4'd8;
    localparam logic [3:0] PH_FAIL = 4'd9;

    logic [7:0] mem [0:LINE_BYTES-2];

    logic [FW-1:0]     fill_reg;
    logic              ovf_reg;
    logic [7:0]        crc_reg, crc_prev_reg, crc_chk_reg;
    logic [31:0]       acc_cnt_reg, rej_cnt_reg, ovl_cnt_reg, ign_cnt_reg;
    logic [1:0]        verdict_reg, vstatus_reg;
    logic              oval_reg;

    logic [3:0]        ph_reg, ph_next;
    logic [31:0]       acc_reg, acc_next;
    logic [3:0]        ndig_reg, ndig_next;
    logic [31:0]       ms_reg, ms_next;
    logic [TLW-1:0]    tcnt_reg, tcnt_next;
    logic [AW-1:0]     tstart_reg, tstart_next, pstart_reg, pstart_next;
    logic [PLEN_W-1:0] plen_reg, plen_next, cnt_reg, cnt_next;
    logic [7:0]        hexv_reg, hexv_next;
    logic [7:0]        b0_reg, b1_reg, b2_reg;
    logic              pfx_ok_reg, pfx_ok_next;
    logic [1:0]        pfx_reg, pfx_next;
    logic [7:0]        crc_chk_next;

    logic [AW-1:0]     ptr_reg;
    logic [TLW-1:0]    trem_reg;
    logic [PLEN_W-1:0] prem_reg;
    logic [7:0]        rdata_reg;
    logic [1:0]        rkind_reg;
    logic              rlast_reg;

    logic        is_cr, do_store, is_dig;
    logic [35:0] dec_val;
    logic [4:0]  hx;
    logic [AW-1:0] wr_idx;
    logic [1:0]  nl_verdict, nl_status;

    assign is_cr    = (rx_byte == CH_CR);
    assign do_store = cmd.store && !is_cr && (fill_reg < FW'(LINE_BYTES - 1));
    assign wr_idx   = fill_reg[AW-1:0];
    assign is_dig   = (rx_byte inside {[8'h30:8'h39]});
    assign dec_val  = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1)
                      + 36'(rx_byte - CH_ZERO);
    assign hx       = hex_val(rx_byte);

    // Frame parser: advances one phase step per stored byte.
    always_comb
    begin
        ph_next      = ph_reg;
        acc_next     = acc_reg;
        ndig_next    = ndig_reg;
        ms_next      = ms_reg;
        tcnt_next    = tcnt_reg;
        tstart_next  = tstart_reg;
        pstart_next  = pstart_reg;
        plen_next    = plen_reg;
        cnt_next     = cnt_reg;
        hexv_next    = hexv_reg;
        pfx_ok_next  = pfx_ok_reg;
        pfx_next     = pfx_reg;
        crc_chk_next = crc_chk_reg;
        if (fill_reg == FW'(3))
        begin
            pfx_ok_next = (rx_byte == CH_SP) && ({b0_reg, b1_reg, b2_reg} == PFX_EVT
                          || {b0_reg, b1_reg, b2_reg} == PFX_CMD
                          || {b0_reg, b1_reg, b2_reg} == PFX_RSP);
            pfx_next    = ({b0_reg, b1_reg, b2_reg} == PFX_CMD) ? PFX_CODE_CMD :
                          ({b0_reg, b1_reg, b2_reg} == PFX_RSP) ? PFX_CODE_RSP :
                          PFX_CODE_EVT;
            ph_next     = PH_MS;
            acc_next    = '0;
            ndig_next   = '0;
        end
        else if (fill_reg > FW'(3))
        begin
            case (ph_reg)
                PH_MS, PH_PLEN:
                begin
                    if (is_dig)
                    begin
                        if (dec_val[35:32] != 4'd0 || ndig_reg == 4'(MAX_DEC_DIGITS))
                            ph_next = PH_FAIL;
                        else
                        begin
                            acc_next  = dec_val[31:0];
                            ndig_next = ndig_reg + 4'd1;
                        end
                    end
                    else if (rx_byte == CH_SP && ndig_reg != 4'd0)
                    begin
                        if (ph_reg == PH_MS)
                        begin
                            ms_next     = acc_reg;
                            tcnt_next   = '0;
                            tstart_next = AW'(fill_reg + FW'(1));
                            ph_next     = PH_TYPE;
                        end
                        else if (acc_reg < 32'(PAYLOAD_MAX))
                        begin
                            plen_next   = acc_reg[PLEN_W-1:0];
                            cnt_next    = acc_reg[PLEN_W-1:0];
                            pstart_next = AW'(fill_reg + FW'(1));
                            ph_next     = (acc_reg == 32'd0) ? PH_STAR : PH_PAY;
                        end
                        else
                            ph_next = PH_FAIL;
                    end
                    else
                        ph_next = PH_FAIL;
                end
                PH_TYPE:
                begin
                    if (rx_byte == CH_SP)
                    begin
                        if (tcnt_reg == '0)
                            ph_next = PH_FAIL;
                        else
                        begin
                            ph_next   = PH_PLEN;
                            acc_next  = '0;
                            ndig_next = '0;
                        end
                    end
                    else if (tcnt_reg == TLW'(TYPE_MAX - 1))
                        ph_next = PH_FAIL;
                    else
                        tcnt_next = tcnt_reg + TLW'(1);
                end
                PH_PAY:
                begin
                    cnt_next = cnt_reg - PLEN_W'(1);
                    if (cnt_reg == PLEN_W'(1))
                        ph_next = PH_SP2;
                end
                PH_SP2:
                begin
                    ph_next = (rx_byte == CH_SP) ? PH_STAR : PH_FAIL;
                end
                PH_STAR:
                begin
                    // The CRC covers everything before the space in front of the star.
                    if (rx_byte == CH_STAR)
                    begin
                        crc_chk_next = crc_prev_reg;
                        ph_next      = PH_HEX1;
                    end
                    else
                        ph_next = PH_FAIL;
                end
                PH_HEX1:
                begin
                    hexv_next[7:4] = hx[3:0];
                    ph_next        = hx[4] ? PH_HEX2 : PH_FAIL;
                end
                PH_HEX2:
                begin
                    hexv_next[3:0] = hx[3:0];
                    ph_next        = hx[4] ? PH_DONE : PH_FAIL;
                end
                default:
                begin
                    ph_next = PH_FAIL;
                end
            endcase
        end
    end

    // Line verdict at the newline.
    always_comb
    begin
        nl_verdict = VERDICT_STATUS;
        nl_status  = ST_MALFORMED;
        if (ovf_reg)
            nl_status = ST_OVERLONG;
        else if (fill_reg == '0)
            nl_verdict = VERDICT_NONE;
        else if (fill_reg < FW'(4) || !pfx_ok_reg)
            nl_status = ST_FOREIGN;
        else if (ph_reg == PH_DONE && hexv_reg == crc_chk_reg)
        begin
            nl_verdict = VERDICT_FRAME;
            nl_status  = ST_COMPLETE;
        end
    end

    assign stat.verdict   = verdict_reg;
    assign stat.slot_free = !oval_reg || res_ready;
    assign stat.run_done  = (trem_reg == '0) && (prem_reg == '0);
    assign stat.rx_is_lf  = (rx_byte == CH_LF);
    assign res_valid      = oval_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            ovf_reg     <= 1'b0;
            crc_reg     <= CRC_INIT;
            acc_cnt_reg <= '0;
            rej_cnt_reg <= '0;
            ovl_cnt_reg <= '0;
            ign_cnt_reg <= '0;
            verdict_reg <= VERDICT_NONE;
            oval_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.store && !is_cr)
            begin
                if (do_store)
                begin
                    fill_reg <= fill_reg + FW'(1);
                    crc_reg  <= crc8_step(crc_reg, rx_byte);
                end
                else
                    ovf_reg <= 1'b1;
            end
            if (cmd.newline)
            begin
                fill_reg    <= '0;
                ovf_reg     <= 1'b0;
                crc_reg     <= CRC_INIT;
                verdict_reg <= nl_verdict;
                if (nl_verdict == VERDICT_FRAME)
                    acc_cnt_reg <= acc_cnt_reg + 32'd1;
                else if (nl_verdict == VERDICT_STATUS)
                begin
                    case (nl_status)
                        ST_OVERLONG: ovl_cnt_reg <= ovl_cnt_reg + 32'd1;
                        ST_FOREIGN:  ign_cnt_reg <= ign_cnt_reg + 32'd1;
                        default:     rej_cnt_reg <= rej_cnt_reg + 32'd1;
                    endcase
                end
            end
            if (cmd.load_status || cmd.load_hdr || cmd.load_data)
                oval_reg <= 1'b1;
            else if (res_ready)
                oval_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_store)
        begin
            mem[wr_idx]  <= rx_byte;
            crc_prev_reg <= crc_reg;
            if (fill_reg == FW'(0)) b0_reg <= rx_byte;
            if (fill_reg == FW'(1)) b1_reg <= rx_byte;
            if (fill_reg == FW'(2)) b2_reg <= rx_byte;
            ph_reg      <= ph_next;
            acc_reg     <= acc_next;
            ndig_reg    <= ndig_next;
            ms_reg      <= ms_next;
            tcnt_reg    <= tcnt_next;
            tstart_reg  <= tstart_next;
            pstart_reg  <= pstart_next;
            plen_reg    <= plen_next;
            cnt_reg     <= cnt_next;
            hexv_reg    <= hexv_next;
            pfx_ok_reg  <= pfx_ok_next;
            pfx_reg     <= pfx_next;
            crc_chk_reg <= crc_chk_next;
        end
        if (cmd.newline)
            vstatus_reg <= nl_status;
        if (cmd.start_run)
        begin
            ptr_reg  <= tstart_reg;
            trem_reg <= tcnt_reg;
            prem_reg <= plen_reg;
        end
        if (cmd.rd)
        begin
            rdata_reg <= mem[ptr_reg];
            rlast_reg <= (32'(trem_reg) + 32'(prem_reg) == 32'd1);
            if (trem_reg != '0)
            begin
                rkind_reg <= KIND_TYPE;
                trem_reg  <= trem_reg - TLW'(1);
                ptr_reg   <= (trem_reg == TLW'(1)) ? pstart_reg : ptr_reg + AW'(1);
            end
            else
            begin
                rkind_reg <= KIND_PAY;
                prem_reg  <= prem_reg - PLEN_W'(1);
                ptr_reg   <= ptr_reg + AW'(1);
            end
        end
        if (cmd.load_status || cmd.load_hdr)
        begin
            status         <= cmd.load_hdr ? ST_COMPLETE : vstatus_reg;
            kind           <= KIND_HDR;
            prefix         <= cmd.load_hdr ? pfx_reg : 2'd0;
            timestamp_ms   <= cmd.load_hdr ? ms_reg : 32'd0;
            type_length    <= cmd.load_hdr ? 4'(tcnt_reg) : 4'd0;
            payload_length <= cmd.load_hdr ? plen_reg : 5'd0;
            data_byte      <= 8'd0;
            last           <= cmd.load_status;
            accepted_count <= acc_cnt_reg;
            rejected_count <= rej_cnt_reg;
            overlong_count <= ovl_cnt_reg;
            ignored_count  <= ign_cnt_reg;
        end
        else if (cmd.load_data)
        begin
            kind      <= rkind_reg;
            data_byte <= rdata_reg;
            last      <= rlast_reg;
        end
    end

endmodule

/* bench/text_frame_line_parser_test.sv */
// Self-checking testbench of the text frame line parser.
// Depends on tflp_pkg and text_frame_line_parser; predicts every result item
// from the byte stream and compares each transfer on the result channel.
module text_frame_line_parser_test;
    import tflp_pkg::*;

    localparam int LINE_LIM    = LINE_BYTES_DEF - 1;
    localparam int TYPE_LIM    = TYPE_MAX_DEF;
    localparam int PAYLOAD_LIM = PAYLOAD_MAX_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 200;

    // One result item as the parser presents it.
    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  kind;
        logic [1:0]  prefix;
        logic [31:0] ms;
        logic [3:0]  tlen;
        logic [4:0]  plen;
        logic [7:0]  data;
        logic        last;
        logic [31:0] n_acc;
        logic [31:0] n_rej;
        logic [31:0] n_long;
        logic [31:0] n_ign;
    } parse_item_t;

    // One row of the directed table: a line of text, and where it is plain to
    // see, the status and counters that its newline must report.
    typedef struct {
        string       text;
        bit          typed;
        logic [1:0]  status;
        logic [31:0] n_acc;
        logic [31:0] n_rej;
        logic [31:0] n_long;
        logic [31:0] n_ign;
    } line_row_t;

    logic        clk;
    logic        rst_n;
    logic        rx_valid;
    logic        rx_ready;
    logic [7:0]  rx_byte;
    logic        res_valid;
    logic        res_ready;
    logic [1:0]  status;
    logic [1:0]  kind;
    logic [1:0]  prefix;
    logic [31:0] timestamp_ms;
    logic [3:0]  type_length;
    logic [4:0]  payload_length;
    logic [7:0]  data_byte;
    logic        last;
    logic [31:0] accepted_count;
    logic [31:0] rejected_count;
    logic [31:0] overlong_count;
    logic [31:0] ignored_count;

    text_frame_line_parser u_dut (
        .clk(clk), .rst_n(rst_n),
        .rx_valid(rx_valid), .rx_ready(rx_ready), .rx_byte(rx_byte),
        .res_valid(res_valid), .res_ready(res_ready),
        .status(status), .kind(kind), .prefix(prefix),
        .timestamp_ms(timestamp_ms), .type_length(type_length),
        .payload_length(payload_length), .data_byte(data_byte), .last(last),
        .accepted_count(accepted_count), .rejected_count(rejected_count),
        .overlong_count(overlong_count), .ignored_count(ignored_count)
    );

    // Predictor state: the line collected so far and the four counters.
    logic [7:0]  line_buf [LINE_LIM];
    int          line_fill;
    bit          line_long;
    logic [31:0] cnt_acc, cnt_rej, cnt_long, cnt_ign;

    parse_item_t pending_items [$];
    int          error_count;
    int          cycle_count;
    bit          hold_off;       // long receiver stall requested by the sender

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Parses a decimal field of 1..10 digits that fits in 32 bits.
    function automatic bit scan_decimal(inout int pos, input int stop,
                                        output logic [31:0] val);
        longint acc;
        int     first;
        acc   = 0;
        first = pos;
        val   = '0;
        while (pos < stop && line_buf[pos] >= "0" && line_buf[pos] <= "9")
        begin
            acc = acc * 10 + (line_buf[pos] - "0");
            if (acc > 64'hFFFF_FFFF)
                return 1'b0;
            pos++;
        end
        if (pos == first || pos - first > MAX_DEC_DIGITS)
            return 1'b0;
        val = acc[31:0];
        return 1'b1;
    endfunction

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "A" && c <= "F") return c - "A" + 10;
        if (c >= "a" && c <= "f") return c - "a" + 10;
        return -1;
    endfunction

    // CRC-8/ATM over the first n bytes of the line, MSB first.
    function automatic logic [7:0] line_crc(input int n);
        logic [7:0] c;
        c = 8'h00;
        for (int i = 0; i < n; i++)
        begin
            c = c ^ line_buf[i];
            for (int b = 0; b < 8; b++)
                c = c[7] ? ((c << 1) ^ 8'h07) : (c << 1);
        end
        return c;
    endfunction

    function automatic parse_item_t status_item(input logic [1:0] st);
        parse_item_t it;
        it        = '0;
        it.status = st;
        it.kind   = KIND_HDR;
        it.last   = 1'b1;
        it.n_acc  = cnt_acc;
        it.n_rej  = cnt_rej;
        it.n_long = cnt_long;
        it.n_ign  = cnt_ign;
        return it;
    endfunction

    // Checks the collected line as a frame and queues what its newline yields.
    function automatic void judge_line();
        int          pos, tstart, tlen, pstart, hi, lo;
        logic [31:0] ms, plen;
        logic [1:0]  pfx;
        parse_item_t it;
        bit          ok;
        logic [23:0] head;

        if (line_long)
        begin
            cnt_long++;
            pending_items.push_back(status_item(ST_OVERLONG));
            return;
        end
        if (line_fill == 0)
            return;
        head = (line_fill >= 3) ? {line_buf[0], line_buf[1], line_buf[2]} : '0;
        if (line_fill < 4 || line_buf[3] != CH_SP ||
            !(head == PFX_EVT || head == PFX_CMD || head == PFX_RSP))
        begin
            cnt_ign++;
            pending_items.push_back(status_item(ST_FOREIGN));
            return;
        end
        pfx = (head == PFX_EVT) ? PFX_CODE_EVT :
              (head == PFX_CMD) ? PFX_CODE_CMD : PFX_CODE_RSP;

        // Walk the fields; any failure drops to a single malformed item.
        ok  = 1'b1;
        pos = 4;
        if (!scan_decimal(pos, line_fill, ms) || pos >= line_fill || line_buf[pos] != CH_SP)
            ok = 1'b0;
        if (ok)
        begin
            pos++;
            tstart = pos;
            while (pos < line_fill && line_buf[pos] != CH_SP)
                pos++;
            tlen = pos - tstart;
            if (tlen == 0 || tlen >= TYPE_LIM || pos >= line_fill)
                ok = 1'b0;
        end
        if (ok)
        begin
            pos++;
            if (!scan_decimal(pos, line_fill, plen) || plen >= PAYLOAD_LIM ||
                pos >= line_fill || line_buf[pos] != CH_SP)
                ok = 1'b0;
        end
        if (ok)
        begin
            pos++;
            pstart = pos;
            if (plen > 0)
            begin
                if (pstart + plen > line_fill)
                    ok = 1'b0;
                else
                begin
                    pos += plen;
                    if (pos >= line_fill || line_buf[pos] != CH_SP)
                        ok = 1'b0;
                    else
                        pos++;
                end
            end
        end
        if (ok && (pos + 3 != line_fill || line_buf[pos] != CH_STAR))
            ok = 1'b0;
        if (ok)
        begin
            hi = hex_nibble(line_buf[pos + 1]);
            lo = hex_nibble(line_buf[pos + 2]);
            if (hi < 0 || lo < 0 || 8'(hi * 16 + lo) != line_crc(pos - 1))
                ok = 1'b0;
        end
        if (!ok)
        begin
            cnt_rej++;
            pending_items.push_back(status_item(ST_MALFORMED));
            return;
        end

        cnt_acc++;
        it        = status_item(ST_COMPLETE);
        it.prefix = pfx;
        it.ms     = ms;
        it.tlen   = 4'(tlen);
        it.plen   = 5'(plen);
        it.last   = (tlen + plen == 0);
        pending_items.push_back(it);
        for (int i = 0; i < tlen + plen; i++)
        begin
            it.kind = (i < tlen) ? KIND_TYPE : KIND_PAY;
            it.data = (i < tlen) ? line_buf[tstart + i] : line_buf[pstart + i - tlen];
            it.last = (i == tlen + plen - 1);
            pending_items.push_back(it);
        end
    endfunction

    // Advances the predictor by one accepted byte.
    function automatic void take_byte(input logic [7:0] c);
        if (c == CH_CR)
            return;
        if (c != CH_LF)
        begin
            if (line_fill < LINE_LIM)
                line_buf[line_fill++] = c;
            else
                line_long = 1'b1;
            return;
        end
        judge_line();
        line_fill = 0;
        line_long = 1'b0;
    endfunction

    // Result checker: every transfer is matched against the oldest expectation.
    always @(posedge clk)
    begin
        parse_item_t got, want;
        if (rst_n && res_valid && res_ready)
        begin
            got = '{status, kind, prefix, timestamp_ms, type_length, payload_length,
                    data_byte, last, accepted_count, rejected_count,
                    overlong_count, ignored_count};
            if (pending_items.size() == 0)
            begin
                $display("%0t: unexpected result, actual %h", $time, got);
                error_count++;
            end
            else
            begin
                want = pending_items.pop_front();
                if (got !== want)
                begin
                    $display("%0t: result mismatch", $time);
                    $display("  expected st=%0d kind=%0d pfx=%0d ms=%0d tl=%0d pl=%0d d=%h last=%0d cnt=%0d/%0d/%0d/%0d",
                             want.status, want.kind, want.prefix, want.ms, want.tlen, want.plen,
                             want.data, want.last, want.n_acc, want.n_rej, want.n_long, want.n_ign);
                    $display("  actual   st=%0d kind=%0d pfx=%0d ms=%0d tl=%0d pl=%0d d=%h last=%0d cnt=%0d/%0d/%0d/%0d",
                             got.status, got.kind, got.prefix, got.ms, got.tlen, got.plen,
                             got.data, got.last, got.n_acc, got.n_rej, got.n_long, got.n_ign);
                    error_count++;
                end
            end
        end
    end

    // Receiver: stalls on its own pattern, and holds off for a long stretch
    // whenever the sender asks, so the parser backs up into its input.
    initial
    begin
        int mode;
        res_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                res_ready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            mode = (cycle_count / 500) % 3;
            if (mode == 0)
                res_ready <= 1'b1;
            else if (mode == 1)
                res_ready <= ($urandom_range(3, 0) != 0);
            else
                res_ready <= ($urandom_range(3, 0) == 0);
        end
    end

    // Watchdog on the cycle counter.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("text_frame_line_parser test failed");
            $finish;
        end
    end

    // Offers one byte and waits for its transfer; gaps fall between bursts.
    int burst_left;
    task automatic send_byte(input logic [7:0] c);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(40, 1);
            if ($urandom_range(2, 0) == 0)
            begin
                rx_valid <= 1'b0;
                repeat ($urandom_range(6, 1)) @(posedge clk);
            end
        end
        burst_left--;
        rx_valid <= 1'b1;
        rx_byte  <= c;
        do
            @(posedge clk);
        while (!rx_ready);
        take_byte(c);
    endtask

    task automatic send_line(input string s);
        foreach (s[i])
            send_byte(s[i]);
        send_byte(CH_LF);
    endtask

    // Builds a frame line with a correct or deliberately spoiled checksum.
    function automatic string make_frame(input int pfx, input logic [31:0] ms,
                                         input string tname, input string pay,
                                         input bit spoil);
        string s, body, hex;
        logic [7:0] c;
        s = (pfx == 0) ? "EVT" : (pfx == 1) ? "CMD" : "RSP";
        body = $sformatf("%s %0d %s %0d ", s, ms, tname, pay.len());
        if (pay.len() > 0)
            body = {body, pay, " "};
        c = 8'h00;
        for (int i = 0; i < body.len() - 1; i++)
        begin
            c = c ^ body[i];
            for (int b = 0; b < 8; b++)
                c = c[7] ? ((c << 1) ^ 8'h07) : (c << 1);
        end
        if (spoil)
            c = c ^ 8'h01;
        if ($urandom_range(1, 0) != 0)
            hex = $sformatf("%02X", c);
        else
            hex = $sformatf("%02x", c);
        return {body, "*", hex};
    endfunction

    function automatic string rand_text(input int n, input bit no_space);
        string s;
        s = "";
        for (int i = 0; i < n; i++)
        begin
            byte c;
            c = byte'($urandom_range(126, 33));
            if (no_space && c == " ")
                c = "x";
            s = {s, string'(c)};
        end
        return s;
    endfunction

    // Any nonzero byte, carriage return included; newlines are remapped.
    function automatic string rand_noise(input int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++)
        begin
            byte c;
            c = byte'($urandom_range(255, 1));
            if (c == CH_LF)
                c = 8'hFF;
            s = {s, string'(c)};
        end
        return s;
    endfunction

    task automatic wait_drained();
        while (pending_items.size() != 0)
            @(posedge clk);
    endtask

    line_row_t directed [$];
    string     long_line;

    initial
    begin
        string line;
        int    kind_pick;
        rst_n         = 1'b0;
        rx_valid      = 1'b0;
        rx_byte       = '0;
        error_count   = 0;
        cycle_count   = 0;
        hold_off      = 1'b0;
        burst_left    = 0;
        line_fill     = 0;
        line_long     = 1'b0;
        cnt_acc = '0; cnt_rej = '0; cnt_long = '0; cnt_ign = '0;

        long_line = "";
        for (int i = 0; i < LINE_LIM + 3; i++)
            long_line = {long_line, "A"};

        // Directed rows: counters here follow from the rows above them.
        directed = '{
            '{"", 0, 0, 0, 0, 0, 0},
            '{"AB", 1, ST_FOREIGN, 0, 0, 0, 1},
            '{"XYZ ok", 1, ST_FOREIGN, 0, 0, 0, 2},
            '{"EVTX 1", 1, ST_FOREIGN, 0, 0, 0, 3},
            '{"EVT x", 1, ST_MALFORMED, 0, 1, 0, 3},
            '{"EVT 4294967296 T 0 *00", 1, ST_MALFORMED, 0, 2, 0, 3},
            '{"CMD 00000000001 T 0 *00", 1, ST_MALFORMED, 0, 3, 0, 3},
            '{"RSP 1 T 32 *00", 1, ST_MALFORMED, 0, 4, 0, 3},
            '{long_line, 1, ST_OVERLONG, 0, 4, 1, 3},
            '{"\r\r", 0, 0, 0, 0, 0, 0},
            '{"EVT 5 TYPE 0 *ZZ", 1, ST_MALFORMED, 0, 5, 1, 3},
            '{"EVT 5 0123456789ABCDEF 0 *00", 1, ST_MALFORMED, 0, 6, 1, 3}
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[r])
        begin
            send_line(directed[r].text);
            if (directed[r].typed)
            begin
                parse_item_t it;
                it = status_item(directed[r].status);
                if (pending_items.size() == 0 || pending_items[$] !== it ||
                    it.n_acc !== directed[r].n_acc || it.n_rej !== directed[r].n_rej ||
                    it.n_long !== directed[r].n_long || it.n_ign !== directed[r].n_ign)
                begin
                    $display("%0t: table row %0d disagrees with prediction", $time, r);
                    error_count++;
                end
            end
        end

        // Frames at the extremes, checked by the predictor.
        send_line(make_frame(0, 32'd0, "T", "", 0));
        send_line(make_frame(1, 32'hFFFF_FFFF, rand_text(TYPE_LIM - 1, 1),
                             rand_text(PAYLOAD_LIM - 1, 0), 0));
        send_line(make_frame(2, 32'd123, "Kx", "\r\x80\xff pay", 0));
        send_line(make_frame(0, 32'd7, "T", "abc", 1));
        send_line({"CMD 1\r T 0 *", "00"});

        // Pause until every expected result has come, then a long hold-off.
        rx_valid <= 1'b0;
        wait_drained();
        hold_off = 1'b1;

        for (int n = 0; n < 300; )
        begin
            kind_pick = $urandom_range(19, 0);
            if (kind_pick < 13)
                line = make_frame($urandom_range(2, 0),
                                  ($urandom_range(1, 0) ? $urandom() : $urandom_range(999, 0)),
                                  rand_text($urandom_range(TYPE_LIM - 1, 1), 1),
                                  rand_text($urandom_range(PAYLOAD_LIM - 1, 0), 0),
                                  $urandom_range(7, 0) == 0);
            else if (kind_pick < 16)
            begin
                // Broken frame: one byte replaced at random.
                line = make_frame($urandom_range(2, 0), $urandom_range(99, 0),
                                  "T", rand_text($urandom_range(8, 0), 0), 0);
                line[$urandom_range(line.len() - 1, 0)] = byte'($urandom_range(255, 1));
                if (line[0] == CH_LF) line[0] = "E";
                for (int i = 0; i < line.len(); i++)
                    if (line[i] == CH_LF) line[i] = " ";
            end
            else if (kind_pick < 18)
                line = rand_noise($urandom_range(20, 0));
            else if (kind_pick < 19)
                line = rand_noise($urandom_range(LINE_LIM + 10, LINE_LIM - 2));
            else
                line = "";
            // A zero byte now and then in front of a noise line.
            if (kind_pick >= 16 && kind_pick < 18 && $urandom_range(3, 0) == 0)
            begin
                send_byte(8'h00);
                n++;
            end
            send_line(line);
            n += line.len() + 1;
            if (n > 60 && n < 200 && $urandom_range(40, 0) == 0)
            begin
                rx_valid <= 1'b0;
                wait_drained();
            end
        end
        rx_valid <= 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_items.size() == 0)
            $display("text_frame_line_parser test passed");
        else
            $display("text_frame_line_parser test failed");
        $finish;
    end

endmodule
